### rtl/tmp_pkg.sv
// Shared types, constants and helpers for the trapezoidal motion profile core.
// Used by tmp_setup, tmp_sample_path, tmp_div_pipe and the top level.
`default_nettype none

package tmp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int WIDE_W    = PROD_W + WORD_W;
  localparam int SCL_W     = PROD_W - FRAC_BITS;
  localparam int HI_W      = SCL_W - WORD_W;
  localparam int LIN_W     = SCL_W + WORD_W - FRAC_BITS;
  localparam int QUAD_W    = LIN_W - 1;
  localparam int DIST_W    = WORD_W + 1;
  localparam int PROG_W    = 16;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = PROG_W / DIV_STEPS;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 6;

  localparam logic [DIST_W-1:0] DIST_SAT = {1'b1, {WORD_W{1'b0}}};
  localparam logic [PROG_W:0]   ONE_PROGRESS = {1'b1, {PROG_W{1'b0}}};

  localparam logic [WORD_W-1:0] RST_PATH_LENGTH = 32'd65536;
  localparam logic [WORD_W-1:0] RST_SPEED_LIMIT = 32'd32768;
  localparam logic [WORD_W-1:0] RST_ACCEL_LIMIT = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATH_LENGTH = 2'd0,
    CFG_SPEED_LIMIT = 2'd1,
    CFG_ACCEL_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VV,
    ST_LA,
    ST_CMP,
    ST_DIV_A,
    ST_SQRT,
    ST_DIV_B,
    ST_DIV_C,
    ST_PEAK,
    ST_HLO,
    ST_HHI,
    ST_CRU
  } setup_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] vel;
    logic [WORD_W-1:0] acc;
    logic [SCL_W-1:0]  peak;
    logic [WORD_W-1:0] t_acc;
    logic [WORD_W:0]   t_two;
    logic [WORD_W-1:0] total;
    logic [DIST_W-1:0] h_acc;
    logic [DIST_W-1:0] h_cru;
  } prof_t;

  typedef struct packed {
    phase_t            phase;
    logic              clamp;
    logic [WORD_W-1:0] rem;
  } dist_word_t;

  function automatic logic [WORD_W-1:0] cap32(input logic [PROD_W-1:0] x);
    cap32 = (|x[PROD_W-1:WORD_W]) ? {WORD_W{1'b1}} : x[WORD_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(input logic [WIDE_W-1:0] x);
    sat_dist = (|x[WIDE_W-1:WORD_W]) ? DIST_SAT : {1'b0, x[WORD_W-1:0]};
  endfunction

endpackage

`default_nettype wire

### rtl/tmp_setup.sv
// Configuration registers and the profile setup sequencer (shared divider,
// square root and multiplier). Depends on tmp_pkg.
`default_nettype none

module tmp_setup (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [tmp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tmp_pkg::WORD_W-1:0]      cfg_wdata,
  output logic                                 busy,
  output tmp_pkg::prof_t                       prof
);

  localparam int W  = tmp_pkg::WORD_W;
  localparam int PW = tmp_pkg::PROD_W;
  localparam int WW = tmp_pkg::WIDE_W;
  localparam int F  = tmp_pkg::FRAC_BITS;

  tmp_pkg::setup_state_t state_r, state_nxt;

  logic [W-1:0] len_r, vel_r, acc_r;
  logic [W-1:0] vel_eff, acc_eff;

  logic [PW-1:0] vv_r, la_r;
  logic          tri_mode_r;
  logic [PW-1:0] dnum_r, dquo_r;
  logic [W:0]    dden_r, drem_r;
  logic [tmp_pkg::CNT_W-1:0] cnt_r;
  logic [PW-1:0] sq_in_r;
  logic [W:0]    sq_rem_r;
  logic [W-1:0]  sq_res_r;
  logic [W-1:0]  t_acc_r, t_cru_r, total_r;
  logic [W:0]    t_two_r;
  logic [tmp_pkg::SCL_W-1:0] a1_r, peak_r;
  logic [PW-1:0] hlo_r;
  logic [tmp_pkg::DIST_W-1:0] h_r, hc_r;

  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] mul_p;

  logic [W+1:0]  drem2;
  logic          dge;
  logic [W:0]    drem_step;
  logic [PW-1:0] dquo_step;
  logic          div_last, sqrt_last;

  logic [W+2:0]  sq_rem4, sq_trial;
  logic          sge;
  logic [W:0]    sq_rem_step;
  logic [W-1:0]  sq_res_step;
  logic          q_ovf;
  logic [PW-1:0] l_minus;

  assign vel_eff = (vel_r == '0) ? W'(1) : vel_r;
  assign acc_eff = (acc_r == '0) ? W'(1) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= tmp_pkg::RST_PATH_LENGTH;
      vel_r <= tmp_pkg::RST_SPEED_LIMIT;
      acc_r <= tmp_pkg::RST_ACCEL_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        tmp_pkg::CFG_PATH_LENGTH: len_r <= cfg_wdata;
        tmp_pkg::CFG_SPEED_LIMIT: vel_r <= cfg_wdata;
        tmp_pkg::CFG_ACCEL_LIMIT: acc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tmp_pkg::ST_VV:   begin mul_a = vel_eff; mul_b = vel_eff; end
      tmp_pkg::ST_LA:   begin mul_a = len_r; mul_b = acc_eff; end
      tmp_pkg::ST_PEAK: begin mul_a = acc_eff; mul_b = t_acc_r; end
      tmp_pkg::ST_HLO:  begin mul_a = a1_r[W-1:0]; mul_b = t_acc_r; end
      tmp_pkg::ST_HHI:  begin mul_a = W'(a1_r[tmp_pkg::SCL_W-1:W]); mul_b = t_acc_r; end
      tmp_pkg::ST_CRU:  begin mul_a = vel_eff; mul_b = t_cru_r; end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // one restoring divide step per cycle
  assign drem2     = {drem_r, dnum_r[PW-1]};
  assign dge       = drem2 >= {1'b0, dden_r};
  assign drem_step = dge ? W'(0) + (W+1)'(drem2 - {1'b0, dden_r}) : drem2[W:0];
  assign dquo_step = {dquo_r[PW-2:0], dge};
  assign div_last  = cnt_r == {tmp_pkg::CNT_W{1'b1}};

  // one result bit per cycle of the square root
  assign sq_rem4     = {sq_rem_r, sq_in_r[PW-1:PW-2]};
  assign sq_trial    = {1'b0, sq_res_r, 2'b01};
  assign sge         = sq_rem4 >= sq_trial;
  assign sq_rem_step = sge ? (W+1)'(sq_rem4 - sq_trial) : sq_rem4[W:0];
  assign sq_res_step = {sq_res_r[W-2:0], sge};
  assign sqrt_last   = cnt_r[tmp_pkg::CNT_W-2:0] == {(tmp_pkg::CNT_W-1){1'b1}};

  assign q_ovf   = |dquo_step[PW-1:PW-F];
  assign l_minus = PW'(len_r) - {dquo_step[PW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmp_pkg::ST_VV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmp_pkg::ST_IDLE:  state_nxt = tmp_pkg::ST_IDLE;
      tmp_pkg::ST_VV:    state_nxt = tmp_pkg::ST_LA;
      tmp_pkg::ST_LA:    state_nxt = tmp_pkg::ST_CMP;
      tmp_pkg::ST_CMP:   state_nxt = tmp_pkg::ST_DIV_A;
      tmp_pkg::ST_DIV_A: begin
        if (div_last) begin
          if (!tri_mode_r) state_nxt = tmp_pkg::ST_DIV_B;
          else if (q_ovf) state_nxt = tmp_pkg::ST_PEAK;
          else state_nxt = tmp_pkg::ST_SQRT;
        end
      end
      tmp_pkg::ST_SQRT:  if (sqrt_last) state_nxt = tmp_pkg::ST_PEAK;
      tmp_pkg::ST_DIV_B: if (div_last) state_nxt = tmp_pkg::ST_DIV_C;
      tmp_pkg::ST_DIV_C: if (div_last) state_nxt = tmp_pkg::ST_PEAK;
      tmp_pkg::ST_PEAK:  state_nxt = tmp_pkg::ST_HLO;
      tmp_pkg::ST_HLO:   state_nxt = tmp_pkg::ST_HHI;
      tmp_pkg::ST_HHI:   state_nxt = tmp_pkg::ST_CRU;
      tmp_pkg::ST_CRU:   state_nxt = tmp_pkg::ST_IDLE;
      default:           state_nxt = tmp_pkg::ST_IDLE;
    endcase
    if (cfg_we) state_nxt = tmp_pkg::ST_VV;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tmp_pkg::ST_VV: vv_r <= mul_p;
      tmp_pkg::ST_LA: la_r <= mul_p;
      tmp_pkg::ST_CMP: begin
        tri_mode_r <= vv_r >= la_r;
        dnum_r     <= (vv_r >= la_r) ? PW'(len_r) << F : PW'(vel_eff) << F;
        dden_r     <= {1'b0, acc_eff};
        drem_r     <= '0;
        dquo_r     <= '0;
        cnt_r      <= '0;
        t_cru_r    <= '0;
      end
      tmp_pkg::ST_DIV_A: begin
        dnum_r <= dnum_r << 1;
        drem_r <= drem_step;
        dquo_r <= dquo_step;
        cnt_r  <= cnt_r + 1'b1;
        if (div_last) begin
          cnt_r <= '0;
          if (tri_mode_r) begin
            t_acc_r  <= {W{1'b1}};
            sq_in_r  <= dquo_step << F;
            sq_rem_r <= '0;
            sq_res_r <= '0;
          end else begin
            t_acc_r <= tmp_pkg::cap32(dquo_step);
            dnum_r  <= vv_r;
            dden_r  <= {acc_eff, 1'b0};
            drem_r  <= '0;
            dquo_r  <= '0;
          end
        end
      end
      tmp_pkg::ST_SQRT: begin
        sq_in_r  <= sq_in_r << 2;
        sq_rem_r <= sq_rem_step;
        sq_res_r <= sq_res_step;
        cnt_r    <= cnt_r + 1'b1;
        if (sqrt_last) t_acc_r <= sq_res_step;
      end
      tmp_pkg::ST_DIV_B: begin
        dnum_r <= dnum_r << 1;
        drem_r <= drem_step;
        dquo_r <= dquo_step;
        cnt_r  <= cnt_r + 1'b1;
        if (div_last) begin
          cnt_r  <= '0;
          dnum_r <= PW'(l_minus[W-1:0]) << F;
          dden_r <= {1'b0, vel_eff};
          drem_r <= '0;
          dquo_r <= '0;
        end
      end
      tmp_pkg::ST_DIV_C: begin
        dnum_r <= dnum_r << 1;
        drem_r <= drem_step;
        dquo_r <= dquo_step;
        cnt_r  <= cnt_r + 1'b1;
        if (div_last) t_cru_r <= tmp_pkg::cap32(dquo_step);
      end
      tmp_pkg::ST_PEAK: begin
        a1_r   <= mul_p[PW-1:F];
        peak_r <= tri_mode_r ? mul_p[PW-1:F] : tmp_pkg::SCL_W'(vel_eff);
      end
      tmp_pkg::ST_HLO: hlo_r <= mul_p;
      tmp_pkg::ST_HHI: begin
        h_r <= tmp_pkg::sat_dist((WW'({mul_p, {W{1'b0}}}) + WW'(hlo_r)) >> (F + 1));
      end
      tmp_pkg::ST_CRU: begin
        hc_r    <= tmp_pkg::sat_dist(WW'(h_r) + WW'(mul_p >> F));
        total_r <= tmp_pkg::cap32(PW'({t_acc_r, 1'b0}) + PW'(t_cru_r));
        t_two_r <= (W+1)'(t_acc_r) + (W+1)'(t_cru_r);
      end
      default: ;
    endcase
  end

  assign busy = state_r != tmp_pkg::ST_IDLE;

  always_comb begin
    prof.len   = len_r;
    prof.vel   = vel_eff;
    prof.acc   = acc_eff;
    prof.peak  = peak_r;
    prof.t_acc = t_acc_r;
    prof.t_two = t_two_r;
    prof.total = total_r;
    prof.h_acc = h_r;
    prof.h_cru = hc_r;
  end

endmodule

`default_nettype wire

### rtl/tmp_sample_path.sv
// Six-stage sample datapath: phase decode, distance products and sums.
// Depends on tmp_pkg; fed with profile values from tmp_setup.
`default_nettype none

module tmp_sample_path (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        in_fire,
  input  wire logic [tmp_pkg::WORD_W-1:0]  sample_time,
  input  wire tmp_pkg::prof_t              prof,
  output logic                             dist_valid,
  output tmp_pkg::dist_word_t              dist_word
);

  localparam int W  = tmp_pkg::WORD_W;
  localparam int PW = tmp_pkg::PROD_W;
  localparam int WW = tmp_pkg::WIDE_W;
  localparam int SW = tmp_pkg::SCL_W;
  localparam int HW = tmp_pkg::HI_W;
  localparam int F  = tmp_pkg::FRAC_BITS;

  tmp_pkg::phase_t ph0, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [W-1:0]  x0, x1_r, x2_r;
  logic [SW-1:0] r0, r1_r;
  logic          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic [PW-1:0]   m_ax_r, lin_lo_r, q_lo_r;
  logic [HW+W-1:0] lin_hi_r, q_hi_r;
  logic [SW-1:0]   a1;
  logic [tmp_pkg::LIN_W-1:0]  lin3_r, lin4_r, diff;
  logic [tmp_pkg::QUAD_W-1:0] quad_r;
  logic [tmp_pkg::DIST_W-1:0] d5_r, base;
  logic [tmp_pkg::DIST_W:0]   dist_sum;
  tmp_pkg::dist_word_t        w6_r;

  // decode phase and local time
  always_comb begin
    ph0 = tmp_pkg::PH_IDLE;
    x0  = sample_time;
    r0  = '0;
    if (sample_time == '0 || sample_time[W-1]) begin
      ph0 = tmp_pkg::PH_IDLE;
    end else if (sample_time >= prof.total) begin
      ph0 = tmp_pkg::PH_DONE;
    end else if (sample_time < prof.t_acc) begin
      ph0 = tmp_pkg::PH_ACCEL;
    end else if ({1'b0, sample_time} < prof.t_two) begin
      ph0 = tmp_pkg::PH_CRUISE;
      x0  = sample_time - prof.t_acc;
      r0  = SW'(prof.vel);
    end else begin
      ph0 = tmp_pkg::PH_DECEL;
      x0  = sample_time - prof.t_two[W-1:0];
      r0  = prof.peak;
    end
  end

  assign a1 = m_ax_r[PW-1:F];

  always_comb begin
    case (p4_r)
      tmp_pkg::PH_ACCEL:  diff = tmp_pkg::LIN_W'(quad_r);
      tmp_pkg::PH_CRUISE: diff = lin4_r;
      tmp_pkg::PH_DECEL:  diff = (lin4_r > tmp_pkg::LIN_W'(quad_r)) ?
                                 lin4_r - tmp_pkg::LIN_W'(quad_r) : '0;
      default:            diff = '0;
    endcase
  end

  always_comb begin
    case (p5_r)
      tmp_pkg::PH_CRUISE: base = prof.h_acc;
      tmp_pkg::PH_DECEL:  base = prof.h_cru;
      default:            base = '0;
    endcase
  end

  assign dist_sum = {1'b0, base} + {1'b0, d5_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= ph0;
      x1_r <= x0;
      r1_r <= r0;

      p2_r     <= p1_r;
      x2_r     <= x1_r;
      m_ax_r   <= prof.acc * x1_r;
      lin_lo_r <= r1_r[W-1:0] * x1_r;
      lin_hi_r <= r1_r[SW-1:W] * x1_r;

      p3_r   <= p2_r;
      q_lo_r <= a1[W-1:0] * x2_r;
      q_hi_r <= a1[SW-1:W] * x2_r;
      lin3_r <= tmp_pkg::LIN_W'((WW'({lin_hi_r, {W{1'b0}}}) + WW'(lin_lo_r)) >> F);

      p4_r   <= p3_r;
      lin4_r <= lin3_r;
      quad_r <= tmp_pkg::QUAD_W'((WW'({q_hi_r, {W{1'b0}}}) + WW'(q_lo_r)) >> (F + 1));

      p5_r <= p4_r;
      d5_r <= tmp_pkg::sat_dist(WW'(diff));

      w6_r.phase <= p5_r;
      w6_r.clamp <= dist_sum >= (tmp_pkg::DIST_W + 1)'(prof.len);
      w6_r.rem   <= dist_sum[W-1:0];
    end
  end

  assign dist_valid = v6_r;
  assign dist_word  = w6_r;

endmodule

`default_nettype wire

### rtl/tmp_div_pipe.sv
// Pipelined restoring divider for distance / path length, two quotient bits
// per stage. Depends on tmp_pkg.
`default_nettype none

module tmp_div_pipe (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic [tmp_pkg::WORD_W-1:0]  len,
  input  wire logic                        in_valid,
  input  wire tmp_pkg::dist_word_t         in_word,
  output logic                             quo_valid,
  output tmp_pkg::dist_word_t              quo_word,
  output logic [tmp_pkg::PROG_W-1:0]       quo
);

  localparam int W  = tmp_pkg::WORD_W;
  localparam int NS = tmp_pkg::DIV_STAGES;
  localparam int QW = tmp_pkg::PROG_W;

  logic                v_r   [NS];
  tmp_pkg::dist_word_t w_r   [NS];
  logic [QW-1:0]       q_r   [NS];
  tmp_pkg::dist_word_t src_w [NS];
  logic [QW-1:0]       src_q [NS];
  tmp_pkg::dist_word_t nxt_w [NS];
  logic [QW-1:0]       nxt_q [NS];

  always_comb begin
    src_w[0] = in_word;
    src_q[0] = '0;
    for (int k = 1; k < NS; k++) begin
      src_w[k] = w_r[k-1];
      src_q[k] = q_r[k-1];
    end
  end

  always_comb begin
    logic [W-1:0]  r;
    logic [W:0]    r2;
    logic [QW-1:0] q;
    for (int k = 0; k < NS; k++) begin
      r = src_w[k].rem;
      q = src_q[k];
      for (int j = 0; j < tmp_pkg::DIV_STEPS; j++) begin
        r2 = {r, 1'b0};
        if (r2 >= {1'b0, len}) begin
          r  = W'(r2 - {1'b0, len});
          q  = {q[QW-2:0], 1'b1};
        end else begin
          r  = r2[W-1:0];
          q  = {q[QW-2:0], 1'b0};
        end
      end
      nxt_w[k]     = src_w[k];
      nxt_w[k].rem = r;
      nxt_q[k]     = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        w_r[k] <= nxt_w[k];
        q_r[k] <= nxt_q[k];
      end
    end
  end

  assign quo_valid = v_r[NS-1];
  assign quo_word  = w_r[NS-1];
  assign quo       = q_r[NS-1];

endmodule

`default_nettype wire

### rtl/trapezoidal_motion_profile_core.sv
// Top level of the trapezoidal motion profile core.
// Instantiates tmp_setup, tmp_sample_path and tmp_div_pipe; uses tmp_pkg.
//
// Takes one sample_time word per clock while in_stall is low and returns
// one result word per sample, in order, through the sample path, divider
// stages and output register. The whole datapath stalls as one when the
// output word is held. After reset and every configuration write the setup
// sequencer recomputes the profile durations with a one-bit per cycle
// divider and square root (trapezoidal: three divides; triangular: a divide
// and the root, or the divide alone if scaled length over acceleration is
// too large for the root); in_stall stays high during that pass.
`default_nettype none

module trapezoidal_motion_profile_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [tmp_pkg::WORD_W-1:0] in_sample_time,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [tmp_pkg::PROG_W:0]               out_progress,
  output logic [2:0]                             out_phase,
  output logic [tmp_pkg::WORD_W-1:0]             out_total_time,
  input  wire logic                              cfg_we,
  input  wire logic [tmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tmp_pkg::WORD_W-1:0]        cfg_wdata
);

  tmp_pkg::prof_t      prof;
  tmp_pkg::dist_word_t dist_word, quo_word;
  logic                busy, adv, in_fire, dist_valid, quo_valid;
  logic [tmp_pkg::PROG_W-1:0] quo;
  logic [tmp_pkg::PROG_W:0]   progress;

  logic                          out_valid_r;
  logic [tmp_pkg::PROG_W:0]      out_progress_r;
  tmp_pkg::phase_t               out_phase_r;
  logic [tmp_pkg::WORD_W-1:0]    out_total_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = busy || !adv;
  assign in_fire  = in_valid && !in_stall;

  tmp_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .prof      (prof)
  );

  tmp_sample_path u_path (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_fire     (in_fire),
    .sample_time (in_sample_time),
    .prof        (prof),
    .dist_valid  (dist_valid),
    .dist_word   (dist_word)
  );

  tmp_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .len       (prof.len),
    .in_valid  (dist_valid),
    .in_word   (dist_word),
    .quo_valid (quo_valid),
    .quo_word  (quo_word),
    .quo       (quo)
  );

  always_comb begin
    case (quo_word.phase)
      tmp_pkg::PH_IDLE: progress = '0;
      tmp_pkg::PH_DONE: progress = tmp_pkg::ONE_PROGRESS;
      default:          progress = quo_word.clamp ? tmp_pkg::ONE_PROGRESS : {1'b0, quo};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_progress_r <= progress;
      out_phase_r    <= quo_word.phase;
      out_total_r    <= prof.total;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_progress   = out_progress_r;
  assign out_phase      = out_phase_r;
  assign out_total_time = out_total_r;

endmodule

`default_nettype wire
